// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge once reset is released.
`define IIDL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check on every rising edge, reset included.
`define IIDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== sv/iidl_pkg.sv =====
// Package for the indexed insert/delete list: request and response types,
// action and status codes, cell control bundle. Depends on nothing.
package iidl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int POS_W        = 7;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef struct packed {
		act_t                      action;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		stat_t                     status;
		logic [COUNT_W-1:0]        count;
		logic signed [DATA_W-1:0]  read_value;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_RD_LOAD,
		CELL_RD_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_READ
	} ctl_state_t;

endpackage

// ===== sv/iidl_cell.sv =====
// One list cell: holds one entry and one read-out stage, trades with neighbors.
// Depends on iidl_pkg.
module iidl_cell import iidl_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] prev_data,
	input  logic signed [DATA_W-1:0] next_data,
	input  logic signed [DATA_W-1:0] next_rd,
	output logic signed [DATA_W-1:0] data,
	output logic signed [DATA_W-1:0] rd
);

	localparam logic [8:0] LIST_POS = 9'(IDX + 1);

	logic [8:0]               pos9;
	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] rd_q;

	assign pos9 = 9'(ctrl.position);
	assign data = data_q;
	assign rd   = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (ctrl.op)
				CELL_INSERT: begin
					if (pos9 == LIST_POS) begin
						data_q <= ctrl.value;
					end else if (pos9 < LIST_POS) begin
						data_q <= prev_data;
					end
				end
				CELL_DELETE: begin
					if (pos9 <= LIST_POS) begin
						data_q <= next_data;
					end
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_RD_LOAD:  rd_q <= data_q;
			CELL_RD_SHIFT: rd_q <= next_rd;
			default:       rd_q <= rd_q;
		endcase
	end

endmodule

// ===== sv/iidl_ctrl.sv =====
// Control for the list: range checks, length, read-out sequencing, response register.
// Depends on iidl_pkg.
module iidl_ctrl import iidl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp,
	output cell_ctrl_t               cell_ctrl,
	input  logic signed [DATA_W-1:0] head_rd
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

	ctl_state_t       state_q, state_d;
	logic [LW-1:0]    len_q, len_d;
	logic [POS_W-1:0] shift_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;
	logic             rsp_load;
	logic             rsp_free;
	logic             accept;
	logic [CW-1:0]    pos_e, len_e;
	logic             ins_ok, rd_ok, full;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == CTL_IDLE) && rsp_free);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pos_e  = CW'(req.position);
	assign len_e  = CW'(len_q);
	assign ins_ok = (req.position != '0) && (pos_e <= len_e + CW'(1));
	assign rd_ok  = (req.position != '0) && (pos_e <= len_e);
	assign full   = (len_q == LW'(CAPACITY));

	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_IDLE: begin
				if (accept && (req.action == ACT_READ) && rd_ok) begin
					state_d = CTL_READ;
				end
			end
			CTL_READ: begin
				if ((shift_q == '0) && rsp_free) begin
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	always_comb begin
		cell_ctrl.op       = CELL_HOLD;
		cell_ctrl.position = req.position;
		cell_ctrl.value    = req.value;
		len_d              = len_q;
		rsp_load           = 1'b0;
		rsp_d.status       = STAT_RANGE;
		rsp_d.read_value   = '0;
		case (state_q)
			CTL_IDLE: begin
				if (accept) begin
					rsp_load = 1'b1;
					case (req.action)
						ACT_INSERT: begin
							if (!ins_ok) begin
								rsp_d.status = STAT_RANGE;
							end else if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								cell_ctrl.op = CELL_INSERT;
								len_d        = len_q + LW'(1);
								rsp_d.status = STAT_DONE;
							end
						end
						ACT_DELETE: begin
							if (rd_ok) begin
								cell_ctrl.op = CELL_DELETE;
								len_d        = len_q - LW'(1);
								rsp_d.status = STAT_DONE;
							end
						end
						ACT_READ: begin
							if (rd_ok) begin
								cell_ctrl.op = CELL_RD_LOAD;
								rsp_load     = 1'b0;
							end
						end
						default: rsp_d.status = STAT_RANGE;
					endcase
				end
			end
			CTL_READ: begin
				if (shift_q != '0) begin
					cell_ctrl.op = CELL_RD_SHIFT;
				end else if (rsp_free) begin
					rsp_load         = 1'b1;
					rsp_d.status     = STAT_DONE;
					rsp_d.read_value = head_rd;
				end
			end
			default: cell_ctrl.op = CELL_HOLD;
		endcase
		rsp_d.count = COUNT_W'(len_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			len_q       <= '0;
			shift_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			if (accept && (req.action == ACT_READ)) begin
				shift_q <= req.position - POS_W'(1);
			end else if ((state_q == CTL_READ) && (shift_q != '0)) begin
				shift_q <= shift_q - POS_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== sv/indexed_insert_delete_list_top.sv =====
// Top level of the indexed insert/delete list: control plus a row of cells.
// Depends on iidl_pkg, iidl_ctrl, iidl_cell.
//
//   Channel   Direction   Handshake             Payload
//   req       in          req_valid/req_stall   req_t (action, position, value)
//   rsp       out         rsp_valid/rsp_stall   rsp_t (status, count, read_value)
//
// Insert, delete and refused requests load the response register as they are accepted;
// the row shifts at once. A read walks the entry down the read-out stages to cell 0.
// One request at a time while a read walks; the response register holds one result.
// Reset clears every cell's entry and the length at once; no clearing pass.
// A stalled response stalls the request side until it drains.
module indexed_insert_delete_list_top import iidl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cell_ctrl_t               cell_ctrl;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic signed [DATA_W-1:0] cell_rd   [CAPACITY];

	iidl_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cell_ctrl (cell_ctrl),
		.head_rd   (cell_rd[0])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_d, next_d, next_r;
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d = '0;
			assign next_r = '0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
			assign next_r = cell_rd[i+1];
		end
		iidl_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.prev_data (prev_d),
			.next_data (next_d),
			.next_rd   (next_r),
			.data      (cell_data[i]),
			.rd        (cell_rd[i])
		);
	end

endmodule

// ===== sv/iidl_checker.sv =====
// Port-level checks for the indexed insert/delete list, bound to the top level.
// Depends on iidl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iidl_checker import iidl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	property p_rsp_hold;
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp);
	endproperty

	property p_no_accept_blocked;
		rsp_valid && rsp_stall |-> req_stall;
	endproperty

	property p_full_count;
		rsp_valid && (rsp.status == STAT_FULL) |-> rsp.count == COUNT_W'(CAPACITY);
	endproperty

	property p_read_value_done;
		rsp_valid && (rsp.read_value != '0) |-> rsp.status == STAT_DONE;
	endproperty

	`IIDL_ASSERT(a_rsp_hold, clk, arst_n, p_rsp_hold, "stalled response changed")
	`IIDL_ASSERT(a_no_accept_blocked, clk, arst_n, p_no_accept_blocked, "request taken on stall")
	`IIDL_ASSERT(a_full_count, clk, arst_n, p_full_count, "full with short list")
	`IIDL_ASSERT(a_read_value_done, clk, arst_n, p_read_value_done, "value on refused request")
	`IIDL_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !rsp_valid, "response during reset")

endmodule

bind indexed_insert_delete_list_top iidl_checker #(.CAPACITY(CAPACITY)) u_iidl_checker (.*);

// ===== test/tb_indexed_insert_delete_list_top.sv =====
// Testbench for indexed_insert_delete_list_top: directed, fill/empty and random requests,
// each response checked against an in-bench list model. Depends on iidl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_indexed_insert_delete_list_top;
	import iidl_pkg::*;

	localparam int LIST_CAP    = CAPACITY_DEF;
	localparam int TAIL_CYCLES = LIST_CAP + 80;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam act_t ACT_UNUSED = act_t'(2'd3);

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	bit   no_idle;
	int   mismatch_count;
	rsp_t pending_rsp[$];
	logic signed [DATA_W-1:0] shadow_cells [LIST_CAP];
	int   shadow_len;

	indexed_insert_delete_list_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic rsp_t apply_list_op(input req_t r);
		rsp_t o;
		int   p;
		o = '0;
		o.status = STAT_RANGE;
		p = r.position;
		case (r.action)
			ACT_INSERT: begin
				if (p >= 1 && p <= shadow_len + 1) begin
					if (shadow_len >= LIST_CAP) begin
						o.status = STAT_FULL;
					end else begin
						for (int j = shadow_len; j >= p; j--)
							shadow_cells[j] = shadow_cells[j-1];
						shadow_cells[p-1] = r.value;
						shadow_len++;
						o.status = STAT_DONE;
					end
				end
			end
			ACT_DELETE: begin
				if (p >= 1 && p <= shadow_len) begin
					for (int j = p - 1; j + 1 < shadow_len; j++)
						shadow_cells[j] = shadow_cells[j+1];
					shadow_cells[shadow_len-1] = '0;
					shadow_len--;
					o.status = STAT_DONE;
				end
			end
			ACT_READ: begin
				if (p >= 1 && p <= shadow_len) begin
					o.status     = STAT_DONE;
					o.read_value = shadow_cells[p-1];
				end
			end
			default: ;
		endcase
		o.count = COUNT_W'(shadow_len);
		return o;
	endfunction

	function automatic int pick_position(input act_t act);
		int limit;
		limit = (act == ACT_INSERT) ? shadow_len + 1 : shadow_len;
		if (limit == 0 || $urandom_range(0, 99) < 12)
			return $urandom_range(0, 127);
		return $urandom_range(1, limit);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < 50)
			$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input act_t act, input int pos,
			input logic signed [DATA_W-1:0] val);
		int gap;
		gap = (!no_idle && $urandom_range(0, 99) < 38) ? $urandom_range(1, 3) : 0;
		repeat (gap) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid    <= 1'b1;
		req.action   <= act;
		req.position <= POS_W'(pos);
		req.value    <= val;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	task automatic run_random_items(input int n);
		int   grow_pct;
		int   roll;
		act_t act;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				grow_pct = ((i / 150) % 2 == 0) ? $urandom_range(70, 85) : $urandom_range(15, 30);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				act = ACT_UNUSED;
			else if (roll < 35)
				act = ACT_READ;
			else if ($urandom_range(0, 99) < grow_pct)
				act = ACT_INSERT;
			else
				act = ACT_DELETE;
			send_request(act, pick_position(act), $urandom);
		end
	endtask

	task automatic test_directed_cases();
		send_request(ACT_READ, 1, 0);
		send_request(ACT_DELETE, 1, 0);
		send_request(ACT_INSERT, 0, 5);
		send_request(ACT_INSERT, 2, 6);
		send_request(ACT_INSERT, 1, VAL_MAX);
		send_request(ACT_INSERT, 1, VAL_MIN);
		send_request(ACT_INSERT, 3, -1);
		send_request(ACT_INSERT, 2, 0);
		for (int p = 1; p <= 5; p++)
			send_request(ACT_READ, p, 0);
		send_request(ACT_READ, 0, 0);
		send_request(ACT_READ, 127, 0);
		send_request(ACT_DELETE, 5, 0);
		send_request(ACT_UNUSED, 1, 0);
		send_request(ACT_DELETE, 4, 0);
		send_request(ACT_DELETE, 1, 0);
		send_request(ACT_READ, 1, 0);
		send_request(ACT_READ, 2, 0);
		send_request(ACT_DELETE, 2, 0);
		send_request(ACT_DELETE, 1, 0);
		send_request(ACT_READ, 1, 0);
		send_request(ACT_INSERT, 127, 0);
	endtask

	task automatic test_fill_and_empty();
		no_idle = 1'b1;
		while (shadow_len < LIST_CAP)
			send_request(ACT_INSERT, $urandom_range(1, shadow_len + 1), $urandom);
		send_request(ACT_INSERT, $urandom_range(1, LIST_CAP), $urandom);
		send_request(ACT_INSERT, LIST_CAP + 1, $urandom);
		send_request(ACT_INSERT, LIST_CAP + 2, $urandom);
		send_request(ACT_READ, LIST_CAP, 0);
		send_request(ACT_READ, 1, 0);
		send_request(ACT_DELETE, LIST_CAP + 1, 0);
		while (shadow_len > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_request(ACT_READ, $urandom_range(1, shadow_len), $urandom);
			send_request(ACT_DELETE, $urandom_range(1, shadow_len), $urandom);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_pause_for_results();
		repeat (4) begin
			run_random_items(25);
			drain_results();
		end
	endtask

	task automatic test_random_mix();
		run_random_items(1250);
	endtask

	always @(negedge clk)
		rsp_stall <= !no_idle && ($urandom_range(0, 99) < 38);

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (req_valid && !req_stall)
			pending_rsp.push_back(apply_list_op(req));
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response status %0d count %0d value %0d",
					rsp.status, rsp.count, rsp.read_value));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
				if (rsp.count !== want.count)
					report_mismatch($sformatf("count got %0d want %0d",
						rsp.count, want.count));
				if (rsp.read_value !== want.read_value)
					report_mismatch($sformatf("read_value got %0d want %0d",
						rsp.read_value, want.read_value));
			end
		end
	end

	initial begin
		#40ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_stall      = 1'b0;
		no_idle        = 1'b0;
		mismatch_count = 0;
		shadow_len     = 0;
		foreach (shadow_cells[i])
			shadow_cells[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_fill_and_empty();
		test_pause_for_results();
		test_random_mix();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/iidl_pkg.sv
sv/iidl_cell.sv
sv/iidl_ctrl.sv
sv/indexed_insert_delete_list_top.sv
sv/iidl_checker.sv
test/tb_indexed_insert_delete_list_top.sv
